// ----- hw/rtl/aes128_pkg.sv -----
// Shared types, tables and byte-level functions for the AES-128 encryption pipeline
package aes128_pkg;

    localparam int NumRounds = 10;

    typedef logic [127:0] block_t;
    typedef logic [3:0]   round_idx_t;

    localparam logic [1:0] CFG_KEY_HIGH = 2'd0;
    localparam logic [1:0] CFG_KEY_LOW  = 2'd1;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] tab [256];
        tab = '{
            8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
            8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
            8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
            8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
            8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
            8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
            8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
            8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
            8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
            8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
            8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
            8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
            8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
            8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
            8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
            8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
        };
        return tab[x];
    endfunction

    function automatic logic [7:0] rcon(input round_idx_t r);
        logic [7:0] v;
        case (r)
            4'd1:    v = 8'h01;
            4'd2:    v = 8'h02;
            4'd3:    v = 8'h04;
            4'd4:    v = 8'h08;
            4'd5:    v = 8'h10;
            4'd6:    v = 8'h20;
            4'd7:    v = 8'h40;
            4'd8:    v = 8'h80;
            4'd9:    v = 8'h1b;
            4'd10:   v = 8'h36;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    // byte i of a block sits at bits 127-8i
    function automatic logic [7:0] get_byte(input block_t b, input int i);
        return b[127 - 8*i -: 8];
    endfunction

endpackage

// ----- hw/rtl/aes128_round_cell.sv -----
// One pipeline cell: one AES round on the state and the next round key in step
module aes128_round_cell #(
    parameter logic [3:0] ROUND = 4'd1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  advance,
    input  logic                  valid_in,
    input  aes128_pkg::block_t    state_in,
    input  aes128_pkg::block_t    key_in,
    output logic                  valid_out,
    output aes128_pkg::block_t    state_out,
    output aes128_pkg::block_t    key_out
);

    aes128_pkg::block_t rk;
    aes128_pkg::block_t ss;
    aes128_pkg::block_t mc;
    aes128_pkg::block_t state_next;
    aes128_pkg::block_t state_reg;
    aes128_pkg::block_t key_reg;
    logic               valid_reg;

    always_comb begin
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, d0, d1, d2, d3;
        for (int i = 0; i < 16; i++) begin
            if (i < 4) begin
                t[i] = aes128_pkg::sbox(aes128_pkg::get_byte(key_in, 12 + ((i + 1) % 4)));
                if (i == 0) begin
                    t[i] = t[i] ^ aes128_pkg::rcon(ROUND);
                end
            end else begin
                t[i] = rk[127 - 8*(i-4) -: 8];
            end
            rk[127 - 8*i -: 8] = aes128_pkg::get_byte(key_in, i) ^ t[i];
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                ss[127 - 8*(4*c + r) -: 8] =
                    aes128_pkg::sbox(aes128_pkg::get_byte(state_in, 4*((c + r) % 4) + r));
            end
        end
        for (int c = 0; c < 4; c++) begin
            a0 = ss[127 - 32*c -: 8];
            a1 = ss[119 - 32*c -: 8];
            a2 = ss[111 - 32*c -: 8];
            a3 = ss[103 - 32*c -: 8];
            d0 = aes128_pkg::xtime(a0);
            d1 = aes128_pkg::xtime(a1);
            d2 = aes128_pkg::xtime(a2);
            d3 = aes128_pkg::xtime(a3);
            mc[127 - 32*c -: 8] = d0 ^ d1 ^ a1 ^ a2 ^ a3;
            mc[119 - 32*c -: 8] = a0 ^ d1 ^ d2 ^ a2 ^ a3;
            mc[111 - 32*c -: 8] = a0 ^ a1 ^ d2 ^ d3 ^ a3;
            mc[103 - 32*c -: 8] = d0 ^ a0 ^ a1 ^ a2 ^ d3;
        end
        state_next = ((ROUND == 4'(aes128_pkg::NumRounds)) ? ss : mc) ^ rk;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= valid_in;
        end
        if (advance) begin
            state_reg <= state_next;
            key_reg   <= rk;
        end
    end

    assign valid_out = valid_reg;
    assign state_out = state_reg;
    assign key_out   = key_reg;

endmodule

// ----- hw/rtl/aes128_block_encrypt_top.sv -----
// Top level of the AES-128 block encryption pipeline
//   channel  | handshake          | payload
//   input    | s_valid / s_ready  | s_block_high, s_block_low
//   result   | m_valid / m_ready  | m_cipher_high, m_cipher_low
//   config   | cfg_we             | cfg_index, cfg_data
// One item per cycle while the chain is not stalled; a whitening stage then ten round cells.
// The chain moves as a whole: it advances when the last cell is empty or taken.
// A stall holds every cell; s_ready is high whenever the chain advances.
// Reset clears the valid bits and the two config key registers; the round key registers keep their values.
module aes128_block_encrypt_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_block_high,
    input  logic [63:0] s_block_low,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_cipher_high,
    output logic [63:0] m_cipher_low
);

    localparam int N = aes128_pkg::NumRounds;

    logic [63:0]        key_high_reg;
    logic [63:0]        key_low_reg;
    logic               advance;
    logic               v [N+1];
    aes128_pkg::block_t st [N+1];
    aes128_pkg::block_t ky [N+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end else if (cfg_we) begin
            if (cfg_index == aes128_pkg::CFG_KEY_HIGH) begin
                key_high_reg <= cfg_data;
            end else if (cfg_index == aes128_pkg::CFG_KEY_LOW) begin
                key_low_reg <= cfg_data;
            end
        end
    end

    assign advance = !v[N] || m_ready;
    assign s_ready = advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v[0] <= 1'b0;
        end else if (advance) begin
            v[0] <= s_valid;
        end
        if (advance) begin
            st[0] <= {s_block_high, s_block_low} ^ {key_high_reg, key_low_reg};
            ky[0] <= {key_high_reg, key_low_reg};
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_round
        aes128_round_cell #(.ROUND(4'(g + 1))) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .advance   (advance),
            .valid_in  (v[g]),
            .state_in  (st[g]),
            .key_in    (ky[g]),
            .valid_out (v[g+1]),
            .state_out (st[g+1]),
            .key_out   (ky[g+1])
        );
    end

    assign m_valid       = v[N];
    assign m_cipher_high = st[N][127:64];
    assign m_cipher_low  = st[N][63:0];

endmodule

// ----- sim/tb_top.sv -----
// Testbench for the AES-128 encryption pipeline: directed and random blocks against a local model
`timescale 1ns / 100ps

module tb_top;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = aes128_pkg::CFG_KEY_HIGH;
    logic [63:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [63:0] s_block_high = '0;
    logic [63:0] s_block_low = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [63:0] m_cipher_high;
    logic [63:0] m_cipher_low;

    localparam logic [1:0] CFG_UNUSED_A = 2'd2;
    localparam logic [1:0] CFG_UNUSED_B = 2'd3;
    localparam int PipeDepth = 11;

    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] lo;
    } cipher_pair_t;

    logic [63:0]  key_hi_q = '0;
    logic [63:0]  key_lo_q = '0;
    cipher_pair_t cipher_due [$];
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    int           hold_off_cycles = 0;
    int           fail_count = 0;

    byte unsigned sbox_lut [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    aes128_block_encrypt_top u_top (.*);

    always #5 aclk = ~aclk;

    function automatic byte unsigned gmul2(input byte unsigned v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic cipher_pair_t encrypt_block(input logic [63:0] pt_hi,
                                                   input logic [63:0] pt_lo);
        byte unsigned rk [11][16];
        byte unsigned st [16];
        byte unsigned tmp [16];
        byte unsigned rc;
        byte unsigned a0, a1, a2, a3;
        byte unsigned t;
        cipher_pair_t res;
        rc = 8'h01;
        for (int i = 0; i < 8; i++) begin
            rk[0][i]     = key_hi_q[63 - 8*i -: 8];
            rk[0][i + 8] = key_lo_q[63 - 8*i -: 8];
            st[i]        = pt_hi[63 - 8*i -: 8];
            st[i + 8]    = pt_lo[63 - 8*i -: 8];
        end
        for (int r = 1; r < 11; r++) begin
            for (int i = 0; i < 16; i++) begin
                if (i < 4) begin
                    t = sbox_lut[rk[r-1][12 + ((i + 1) % 4)]];
                    if (i == 0) t ^= rc;
                end else begin
                    t = rk[r][i-4];
                end
                rk[r][i] = rk[r-1][i] ^ t;
            end
            rc = gmul2(rc);
        end
        for (int i = 0; i < 16; i++) st[i] ^= rk[0][i];
        for (int r = 1; r < 11; r++) begin
            for (int c = 0; c < 4; c++)
                for (int w = 0; w < 4; w++)
                    tmp[4*c + w] = sbox_lut[st[4*((c + w) % 4) + w]];
            st = tmp;
            if (r < 10) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
                    st[4*c]   = gmul2(a0) ^ gmul2(a1) ^ a1 ^ a2 ^ a3;
                    st[4*c+1] = a0 ^ gmul2(a1) ^ gmul2(a2) ^ a2 ^ a3;
                    st[4*c+2] = a0 ^ a1 ^ gmul2(a2) ^ gmul2(a3) ^ a3;
                    st[4*c+3] = gmul2(a0) ^ a0 ^ a1 ^ a2 ^ gmul2(a3);
                end
            end
            for (int i = 0; i < 16; i++) st[i] ^= rk[r][i];
        end
        for (int i = 0; i < 8; i++) begin
            res.hi[63 - 8*i -: 8] = st[i];
            res.lo[63 - 8*i -: 8] = st[i + 8];
        end
        return res;
    endfunction

    task automatic write_key(input logic [1:0] idx, input logic [63:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        if (idx == aes128_pkg::CFG_KEY_HIGH) key_hi_q = val;
        else if (idx == aes128_pkg::CFG_KEY_LOW) key_lo_q = val;
        @(posedge aclk);
    endtask

    task automatic send_block(input logic [63:0] hi, input logic [63:0] lo);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_block_high <= hi;
        s_block_low  <= lo;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        cipher_due.push_back(encrypt_block(hi, lo));
    endtask

    task automatic drain_pipe();
        s_valid <= 1'b0;
        while (cipher_due.size() != 0) @(posedge aclk);
        repeat (PipeDepth + 4) @(posedge aclk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // mix of sparse, dense and plain random words
    function automatic logic [63:0] shaped64();
        case ($urandom_range(5))
            0: return 64'd1 << $urandom_range(63);
            1: return ~(64'd1 << $urandom_range(63));
            default: return rand64();
        endcase
    endfunction

    task automatic test_reset_key();
        send_block('0, '0);
        send_block('1, '1);
        drain_pipe();
    endtask

    task automatic test_standard_vector();
        write_key(aes128_pkg::CFG_KEY_HIGH, 64'h0001020304050607);
        write_key(aes128_pkg::CFG_KEY_LOW,  64'h08090a0b0c0d0e0f);
        send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
        send_block(64'h8000000000000000, 64'h0000000000000001);
        drain_pipe();
        write_key(aes128_pkg::CFG_KEY_HIGH, 64'h2b7e151628aed2a6);
        write_key(aes128_pkg::CFG_KEY_LOW,  64'habf7158809cf4f3c);
        send_block(64'h3243f6a8885a308d, 64'h313198a2e0370734);
        drain_pipe();
    endtask

    task automatic test_key_extremes();
        write_key(aes128_pkg::CFG_KEY_HIGH, '1);
        write_key(aes128_pkg::CFG_KEY_LOW,  '1);
        send_block('0, '0);
        send_block('1, '1);
        send_block(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
        drain_pipe();
        write_key(CFG_UNUSED_A, rand64());
        write_key(CFG_UNUSED_B, rand64());
        send_block(64'h0123456789abcdef, 64'hfedcba9876543210);
        drain_pipe();
        write_key(aes128_pkg::CFG_KEY_HIGH, '0);
        write_key(aes128_pkg::CFG_KEY_LOW,  '1);
        send_block('1, '0);
        drain_pipe();
    endtask

    task automatic test_random_phase(input int n, input int idle, input int stall);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        write_key(aes128_pkg::CFG_KEY_HIGH, shaped64());
        write_key(aes128_pkg::CFG_KEY_LOW,  shaped64());
        for (int i = 0; i < n; i++) send_block(shaped64(), shaped64());
        drain_pipe();
    endtask

    task automatic test_backpressure();
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_off_cycles = 60;
        for (int i = 0; i < 30; i++) send_block(rand64(), rand64());
        drain_pipe();
        // pause until all results are back, then resume
        for (int i = 0; i < 10; i++) send_block(rand64(), rand64());
        drain_pipe();
    endtask

    always @(posedge aclk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        cipher_pair_t exp_c;
        if (aresetn && m_valid && m_ready) begin
            if (cipher_due.size() == 0) begin
                $error("cipher result with nothing pending: %h %h",
                       m_cipher_high, m_cipher_low);
                fail_count++;
            end else begin
                exp_c = cipher_due.pop_front();
                if (m_cipher_high !== exp_c.hi) begin
                    $error("cipher_high expected %h actual %h", exp_c.hi, m_cipher_high);
                    fail_count++;
                end
                if (m_cipher_low !== exp_c.lo) begin
                    $error("cipher_low expected %h actual %h", exp_c.lo, m_cipher_low);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_key();
        test_standard_vector();
        test_key_extremes();
        test_backpressure();
        test_random_phase(220, 0, 0);
        test_random_phase(220, 54, 0);
        test_random_phase(220, 0, 54);
        test_random_phase(200, 8, 8);
        if (cipher_due.size() != 0) begin
            $error("%0d cipher results never arrived", cipher_due.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
